/* rtl/pi2_pkg.sv */
// Shared types and constants for the 2x polyphase interpolator.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package pi2_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int PROD_W    = SAMPLE_W + COEF_W;
  localparam int TAPS_W    = 7;
  localparam int TAP_IDX_W = 6;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [TAPS_W-1:0] TAPS_RESET = 7'd63;

  // register index, taken from paddr[2]
  localparam logic REG_TAPS_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_TAP    = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  // tag that travels with each multiply-accumulate step
  typedef struct packed {
    logic vld;
    logic zero;   // empty phase: contributes nothing
    logic dval;   // history slot holds a written sample
    logic first;  // k == 0: use current sample, restart sum
    logic fin;    // last step of the phase
    logic phase;
  } mac_tag_t;

  typedef struct packed {
    logic                       vld;
    logic                       phase;
    logic signed [SAMPLE_W-1:0] value;
  } mac_res_t;

endpackage

`default_nettype wire

/* rtl/pi2_if.sv */
// Stream channel interfaces for the interpolator: request in, result out.
// Depends on pi2_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pi2_in_if import pi2_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic signed [SAMPLE_W-1:0]  sample;
  logic [TAP_IDX_W-1:0]        tap_index;
  logic signed [COEF_W-1:0]    tap_value;

  modport source (output valid, req_type, sample, tap_index, tap_value, input ready);
  modport sink   (input valid, req_type, sample, tap_index, tap_value, output ready);
endinterface

interface pi2_out_if import pi2_pkg::*;;
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_W-1:0]  out_sample;
  logic                        phase;
  logic                        last;

  modport source (output valid, out_sample, phase, last, input ready);
  modport sink   (input valid, out_sample, phase, last, output ready);
endinterface

`default_nettype wire

/* rtl/polyphase_interpolator_2x_top.sv */
// Top level of the 2x polyphase interpolator: APB register, coefficient and
// history RAMs, sequencer, shared MAC, result buffer. Depends on pi2_pkg,
// pi2_if, pi2_ram, pi2_seq and pi2_mac.
`timescale 1ns / 1ps
`default_nettype none

// Each sample item gives two result items, phase 0 then phase 1 (last set on
// the second). One multiplier is shared by all taps, so a sample runs in
// steps, for t = taps_in_use clipped to 1..MAX_TAPS: a check that the result
// buffer is empty, one multiply-accumulate per tap (one more when t is 1, as
// the empty phase still takes one step), a push of the sample into the
// history and a drain of the MAC pipeline; only then is the next item taken.
// Stalled results hold a sample at the check. Tap write and clear items are
// taken in the idle state and give no result. A sample is accepted while
// earlier results still wait in the two-entry result buffer; it starts once
// they are taken. The history is a circular buffer in RAM with one valid bit
// per slot, so reset and clear items take effect at once with no clearing
// pass. Coefficients must be written before any sample uses them.

module polyphase_interpolator_2x_top import pi2_pkg::*; #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  pi2_in_if.sink                 din,
  pi2_out_if.source              dout,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam int HIST = MAX_TAPS / 2;
  localparam int CAW  = $clog2(MAX_TAPS);
  localparam int HAW  = (HIST > 1) ? $clog2(HIST) : 1;

  logic [TAPS_W-1:0]          taps_in_use;
  logic                       cfg_wr;
  logic                       in_fire, out_fire;
  logic                       seq_ready;
  logic                       coef_we;
  logic [CAW-1:0]             coef_raddr;
  logic [COEF_W-1:0]          coef_rd;
  logic [HAW-1:0]             hist_raddr, hist_waddr;
  logic                       hist_we;
  logic [SAMPLE_W-1:0]        hist_wdata, hist_rd;
  mac_tag_t                   tag;
  logic signed [SAMPLE_W-1:0] cur;
  logic                       mac_busy;
  mac_res_t                   res;
  logic [1:0]                 ov;       // result buffer occupancy, by phase
  logic [1:0]                 ov_next;
  logic [SAMPLE_W-1:0]        rbuf [2];
  logic                       sel;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_TAPS_IN_USE) ? DATA_W'(taps_in_use) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      taps_in_use <= TAPS_RESET;
    end else if (cfg_wr && paddr[2] == REG_TAPS_IN_USE) begin
      taps_in_use <= pwdata[TAPS_W-1:0];
    end
  end

  // ---- input side ----
  assign din.ready = seq_ready;
  assign in_fire   = din.valid & seq_ready;

  // tap writes beyond the store are dropped
  assign coef_we = in_fire && (din.req_type == REQ_TAP) && (32'(din.tap_index) < MAX_TAPS);

  pi2_ram #(.WIDTH(COEF_W), .DEPTH(MAX_TAPS)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (CAW'(din.tap_index)),
    .wdata (din.tap_value),
    .raddr (coef_raddr),
    .rdata (coef_rd)
  );

  pi2_ram #(.WIDTH(SAMPLE_W), .DEPTH(HIST)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (hist_raddr),
    .rdata (hist_rd)
  );

  pi2_seq #(.MAX_TAPS(MAX_TAPS)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_fire    (in_fire),
    .in_req     (din.req_type),
    .in_sample  (din.sample),
    .taps       (taps_in_use),
    .out_empty  (ov == 2'b00),
    .mac_busy   (mac_busy),
    .ready      (seq_ready),
    .coef_raddr (coef_raddr),
    .hist_raddr (hist_raddr),
    .hist_we    (hist_we),
    .hist_waddr (hist_waddr),
    .hist_wdata (hist_wdata),
    .tag        (tag),
    .cur        (cur)
  );

  pi2_mac #(.MAX_TAPS(MAX_TAPS)) u_mac (
    .clk     (clk),
    .rst     (rst),
    .tag     (tag),
    .cur     (cur),
    .coef_rd (signed'(coef_rd)),
    .hist_rd (hist_rd),
    .busy    (mac_busy),
    .res     (res)
  );

  // ---- result buffer: one slot per phase, phase 0 drains first ----
  assign sel             = ~ov[0];
  assign dout.valid      = |ov;
  assign dout.out_sample = signed'(rbuf[sel]);
  assign dout.phase      = sel;
  assign dout.last       = sel;
  assign out_fire        = dout.valid & dout.ready;

  always_comb begin
    ov_next = ov;
    if (out_fire) begin
      ov_next[sel] = 1'b0;
    end
    if (res.vld) begin
      ov_next[res.phase] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 2'b00;
    end else begin
      ov <= ov_next;
    end
    if (res.vld) begin
      rbuf[res.phase] <= res.value;
    end
  end

endmodule

`default_nettype wire

/* rtl/pi2_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module pi2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/pi2_mac.sv */
// Shared multiply-accumulate: multiply, accumulate, round and saturate.
// Depends on pi2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pi2_mac import pi2_pkg::*; #(
  parameter int MAX_TAPS = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire mac_tag_t                   tag,
  input  wire logic signed [SAMPLE_W-1:0] cur,
  input  wire logic signed [COEF_W-1:0]   coef_rd,
  input  wire logic        [SAMPLE_W-1:0] hist_rd,
  output logic                            busy,
  output mac_res_t                        res
);

  localparam int ACC_W = PROD_W + $clog2(MAX_TAPS);

  mac_tag_t                   tag2, tag3;
  logic signed [SAMPLE_W-1:0] x;
  logic signed [COEF_W-1:0]   coef_m;
  logic signed [PROD_W-1:0]   prod;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W:0]      rsum;
  logic signed [ACC_W:0]      q;

  always_comb begin
    if (tag.zero) begin
      x = '0;
    end else if (tag.first) begin
      x = cur;
    end else if (tag.dval) begin
      x = signed'(hist_rd);
    end else begin
      x = '0;
    end
    coef_m = tag.zero ? '0 : coef_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag2 <= '0;
      tag3 <= '0;
    end else begin
      tag2 <= tag;
      tag3 <= tag2;
    end
    prod <= x * coef_m;
    if (tag2.vld) begin
      acc <= tag2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
    end
  end

  // x2 and Q2.32 -> Q1.15 is one shift by 16, rounded half up
  always_comb begin
    rsum = (ACC_W+1)'(acc) + (ACC_W+1)'(32768);
    q    = rsum >>> 16;
    if (q > 32767) begin
      res.value = 16'sh7fff;
    end else if (q < -32768) begin
      res.value = 16'sh8000;
    end else begin
      res.value = q[SAMPLE_W-1:0];
    end
    res.vld   = tag3.vld & tag3.fin;
    res.phase = tag3.phase;
  end

  assign busy = tag2.vld | tag3.vld;

endmodule

`default_nettype wire

/* rtl/pi2_seq.sv */
// Sequencer: walks the taps of each phase, owns the history pointers
// and valid bits. Depends on pi2_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pi2_seq import pi2_pkg::*; #(
  parameter int MAX_TAPS = 64,
  localparam int HIST = MAX_TAPS / 2,
  localparam int CAW  = $clog2(MAX_TAPS),
  localparam int HAW  = (HIST > 1) ? $clog2(HIST) : 1
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_fire,
  input  wire logic [1:0]                 in_req,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  input  wire logic [TAPS_W-1:0]          taps,
  input  wire logic                       out_empty,
  input  wire logic                       mac_busy,
  output logic                            ready,
  output logic [CAW-1:0]                  coef_raddr,
  output logic [HAW-1:0]                  hist_raddr,
  output logic                            hist_we,
  output logic [HAW-1:0]                  hist_waddr,
  output logic [SAMPLE_W-1:0]             hist_wdata,
  output mac_tag_t                        tag,
  output logic signed [SAMPLE_W-1:0]      cur
);

  localparam int TW  = $clog2(MAX_TAPS + 1);
  localparam int CNW = TW + 1;

  typedef enum logic [1:0] {S_IDLE, S_WAIT, S_RUN, S_SHIFT} state_t;

  state_t          state;
  logic [TW-1:0]   t_eff;
  logic [CNW-1:0]  c;
  logic [HAW-1:0]  wptr, rp, wptr_m1, rp_dec, wptr_inc;
  logic [HIST-1:0] hv;
  logic            first_k, phase, last_step, dummy;

  always_comb begin
    if (taps == '0) begin
      t_eff = TW'(1);
    end else if (32'(taps) > MAX_TAPS) begin
      t_eff = TW'(MAX_TAPS);
    end else begin
      t_eff = TW'(taps);
    end
    last_step = (c + CNW'(2)) >= {1'b0, t_eff};
    dummy     = c >= {1'b0, t_eff};
    wptr_m1   = (wptr == '0) ? HAW'(HIST - 1) : wptr - HAW'(1);
    rp_dec    = (rp == '0) ? HAW'(HIST - 1) : rp - HAW'(1);
    wptr_inc  = (wptr == HAW'(HIST - 1)) ? '0 : wptr + HAW'(1);
  end

  assign ready      = (state == S_IDLE) && !mac_busy && !tag.vld;
  assign coef_raddr = c[CAW-1:0];
  assign hist_raddr = rp;
  assign hist_we    = (state == S_SHIFT);
  assign hist_waddr = wptr;
  assign hist_wdata = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      tag     <= '0;
      hv      <= '0;
      wptr    <= '0;
      rp      <= '0;
      c       <= '0;
      phase   <= 1'b0;
      first_k <= 1'b0;
    end else begin
      if (state != S_RUN) begin
        tag <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_req)
              REQ_SAMPLE: begin
                cur   <= in_sample;
                state <= S_WAIT;
              end
              REQ_CLEAR: hv <= '0;
              default: ;
            endcase
          end
        end
        S_WAIT: begin
          // hold off until the previous item's results are taken
          if (out_empty) begin
            state   <= S_RUN;
            c       <= '0;
            phase   <= 1'b0;
            first_k <= 1'b1;
            rp      <= wptr_m1;
          end
        end
        S_RUN: begin
          tag <= '{vld: 1'b1, zero: dummy, dval: hv[rp], first: first_k,
                   fin: last_step, phase: phase};
          if (last_step) begin
            if (!phase) begin
              phase   <= 1'b1;
              c       <= CNW'(1);
              first_k <= 1'b1;
              rp      <= wptr_m1;
            end else begin
              state <= S_SHIFT;
            end
          end else begin
            c       <= c + CNW'(2);
            first_k <= 1'b0;
            if (!first_k) begin
              rp <= rp_dec;
            end
          end
        end
        S_SHIFT: begin
          hv[wptr] <= 1'b1;
          wptr     <= wptr_inc;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/pi2_chk.sv */
// Port-level assertions for the interpolator top, bound into it.
// Depends on pi2_pkg and polyphase_interpolator_2x_top.
`timescale 1ns / 1ps
`default_nettype none

module pi2_chk import pi2_pkg::*; (
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic [1:0]          in_req_type,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SAMPLE_W-1:0] out_sample,
  input wire logic                out_phase,
  input wire logic                out_last
);

  // last marks exactly the second item of a sample
  a_last_phase: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == out_phase))
    else $error("last does not match phase");

  // a sample keeps the block busy for at least the next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && in_req_type == REQ_SAMPLE) |=> !in_ready)
    else $error("ready right after a sample item");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_sample) && $stable(out_phase)))
    else $error("stalled result item changed");

  // no result item straight out of reset
  a_rst_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result item shown after reset");

endmodule

bind polyphase_interpolator_2x_top pi2_chk u_pi2_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (din.valid),
  .in_ready    (din.ready),
  .in_req_type (din.req_type),
  .out_valid   (dout.valid),
  .out_ready   (dout.ready),
  .out_sample  (dout.out_sample),
  .out_phase   (dout.phase),
  .out_last    (dout.last)
);

`default_nettype wire

/* tb/polyphase_interpolator_2x_top_tb.sv */
// Self-checking testbench for the 2x polyphase interpolator top level.
// Needs pi2_pkg, pi2_if and the RTL; drives the request stream and the APB
// register, and predicts every result item in a scoreboard.
`timescale 1ns / 1ps

module polyphase_interpolator_2x_top_tb import pi2_pkg::*;;

  localparam int MAX_TAPS      = 64;
  localparam int HIST_DEPTH    = MAX_TAPS / 2;
  // margin past the slowest sample for a tap write or clear still in flight
  // after the last result
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int HOLD_OFF_CYCLES = 400;

  localparam logic [1:0]        REQ_UNKNOWN = 2'd3;
  localparam logic [ADDR_W-1:0] TAPS_ADDR   = {REG_TAPS_IN_USE, 2'b00};

  localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = 16'sh8000;
  localparam logic signed [COEF_W-1:0]   COEF_MAX = 18'sh1FFFF;
  localparam logic signed [COEF_W-1:0]   COEF_MIN = 18'sh20000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       phase;
    logic                       last;
  } interp_out_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  pi2_in_if  din_if ();
  pi2_out_if dout_if ();

  polyphase_interpolator_2x_top #(
    .MAX_TAPS (MAX_TAPS)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow state of the filter, updated at the edge that accepts each item.
  logic [TAPS_W-1:0]          taps_reg;
  logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];  // [0] is the newest past sample
  logic signed [COEF_W-1:0]   coefs [MAX_TAPS];
  interp_out_t                pending_outputs [$];

  int fail_count;
  int src_idle_pct;
  int sink_stall_pct;
  int hold_left;      // long receiver hold-off, counted down in the ready process

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // register value clipped to the range the filter can use
  function automatic int taps_effective();
    if (taps_reg < 1) return 1;
    if (taps_reg > MAX_TAPS) return MAX_TAPS;
    return int'(taps_reg);
  endfunction

  // One polyphase branch: sum of x[n-k] * c[2k+ph], scaled by 2/2^17 (one
  // shift of 16), rounded half up, saturated to Q1.15. An empty branch gives 0.
  function automatic logic signed [SAMPLE_W-1:0] branch_output(
    input int ph, input logic signed [SAMPLE_W-1:0] cur);
    longint                     acc;
    longint                     scaled;
    int                         t;
    int                         k;
    logic signed [SAMPLE_W-1:0] x;
    t   = taps_effective();
    acc = 0;
    for (k = 0; 2 * k + ph < t; k++) begin
      if (k == 0) x = cur;
      else        x = history[k - 1];
      acc += longint'(x) * longint'(coefs[2 * k + ph]);
    end
    scaled = (acc + 64'sd32768) >>> 16;
    if (scaled > 32767)  return SMP_MAX;
    if (scaled < -32768) return SMP_MIN;
    return scaled[SAMPLE_W-1:0];
  endfunction

  task automatic predict_sample(input logic signed [SAMPLE_W-1:0] cur);
    interp_out_t r;
    for (int ph = 0; ph < 2; ph++) begin
      r.value = branch_output(ph, cur);
      r.phase = ph[0];
      r.last  = (ph == 1);
      pending_outputs.push_back(r);
    end
    for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i - 1];
    history[0] = cur;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    interp_out_t want;
    if (!rst && dout_if.valid && dout_if.ready) begin
      if (pending_outputs.size() == 0) begin
        $error("result item with nothing predicted: out_sample %0d phase %0d last %0d",
               dout_if.out_sample, dout_if.phase, dout_if.last);
        fail_count++;
      end else begin
        want = pending_outputs.pop_front();
        if (dout_if.out_sample !== want.value) begin
          $error("out_sample: expected %0d, got %0d", want.value, dout_if.out_sample);
          fail_count++;
        end
        if (dout_if.phase !== want.phase) begin
          $error("phase: expected %0d, got %0d", want.phase, dout_if.phase);
          fail_count++;
        end
        if (dout_if.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, dout_if.last);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is armed.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      dout_if.ready = 1'b0;
      hold_left     = hold_left - 1;
    end else begin
      dout_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one item (after a random idle gap) and hold it until accepted.
  // valid stays high between back-to-back items.
  task automatic send_item(input logic [1:0] kind,
                           input logic signed [SAMPLE_W-1:0] smp,
                           input logic [TAP_IDX_W-1:0] idx,
                           input logic signed [COEF_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      din_if.valid = 1'b0;
      @(negedge clk);
    end
    din_if.valid     = 1'b1;
    din_if.req_type  = kind;
    din_if.sample    = smp;
    din_if.tap_index = idx;
    din_if.tap_value = val;
    do @(posedge clk); while (!din_if.ready);
    case (kind)
      REQ_SAMPLE: predict_sample(smp);
      REQ_TAP:    coefs[idx] = val;
      REQ_CLEAR:  foreach (history[i]) history[i] = '0;
      default:    ;  // unknown request: dropped by the block
    endcase
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp);
    send_item(REQ_SAMPLE, smp, TAP_IDX_W'($urandom), COEF_W'($urandom));
  endtask

  task automatic send_tap(input logic [TAP_IDX_W-1:0] idx,
                          input logic signed [COEF_W-1:0] val);
    send_item(REQ_TAP, SAMPLE_W'($urandom), idx, val);
  endtask

  // extremes and near-zero values get extra weight
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return SAMPLE_W'($urandom_range(8) - 4);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_W-1:0] rand_coef();
    case ($urandom_range(7))
      0:       return COEF_MAX;
      1:       return COEF_MIN;
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Mostly samples; tap rewrites, history clears and unknown requests mixed in.
  task automatic send_random_item();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 82)      send_sample(rand_sample());
    else if (pick < 90) send_tap(TAP_IDX_W'($urandom_range(MAX_TAPS - 1)), rand_coef());
    else if (pick < 96) send_item(REQ_CLEAR, SAMPLE_W'($urandom), TAP_IDX_W'($urandom),
                                  COEF_W'($urandom));
    else                send_item(REQ_UNKNOWN, SAMPLE_W'($urandom), TAP_IDX_W'($urandom),
                                  COEF_W'($urandom));
  endtask

  // Drop valid, let every predicted result arrive, then let the block settle.
  task automatic wait_idle();
    @(negedge clk);
    din_if.valid = 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup then access phase; pready is sampled on the access edge.
  task automatic apb_access(input bit wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = TAPS_ADDR;
    pwdata  = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_taps_readback();
    logic [DATA_W-1:0] rd;
    apb_access(1'b0, '0, rd);
    if (rd[TAPS_W-1:0] !== taps_reg) begin
      $error("taps_in_use: expected %0d, got %0d", taps_reg, rd[TAPS_W-1:0]);
      fail_count++;
    end
  endtask

  // Register writes only with the datapath idle.
  task automatic set_taps(input logic [TAPS_W-1:0] v);
    logic [DATA_W-1:0] rd;
    wait_idle();
    apb_access(1'b1, DATA_W'(v), rd);
    taps_reg = v;
    check_taps_readback();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_reset_value();
    check_taps_readback();
  endtask

  // Every coefficient slot gets written before the first sample.
  task automatic test_load_coefficients();
    send_tap(0, COEF_MAX);
    send_tap(1, COEF_MIN);
    for (int i = 2; i < MAX_TAPS; i++) send_tap(TAP_IDX_W'(i), rand_coef());
  endtask

  // Reset tap count, extremes, unknown request, tap rewrite, clear.
  task automatic test_directed();
    send_sample(SMP_MAX);
    send_sample(SMP_MIN);
    send_sample(0);
    send_sample(1);
    send_sample(-1);
    send_item(REQ_UNKNOWN, SMP_MAX, '1, COEF_MAX);
    send_sample(SMP_MAX);
    send_tap(0, COEF_MIN);
    send_tap(MAX_TAPS - 1, COEF_MAX);
    send_sample(SMP_MIN);
    send_item(REQ_CLEAR, SMP_MIN, '0, COEF_MIN);
    send_sample(100);
    send_sample(-100);
  endtask

  task automatic test_edge_cases();
    // one tap: phase 1 is empty; rounding at the half-LSB points
    set_taps(1);
    send_tap(0, -1);
    send_sample(SMP_MIN);   // +0.5 LSB rounds up to 1
    send_sample(SMP_MAX);
    send_sample(1);
    send_sample(-1);
    // zero taps is treated as one
    set_taps(0);
    send_sample(12345);
    send_sample(SMP_MIN);
    // full-scale coefficients: saturate both ways
    set_taps(4);
    for (int i = 0; i < 4; i++) send_tap(TAP_IDX_W'(i), COEF_MAX);
    repeat (3) send_sample(SMP_MAX);
    repeat (2) send_sample(SMP_MIN);
    // above the store size: clipped to MAX_TAPS
    set_taps(127);
    send_sample(rand_sample());
    send_sample(rand_sample());
    set_taps(65);
    send_sample(rand_sample());
    set_taps(MAX_TAPS);
    send_sample(rand_sample());
  endtask

  // Random traffic under each idle/stall mix, a different tap register value each time.
  task automatic test_random_phases();
    int src_plan  [4] = '{0, 51, 0, 32};
    int sink_plan [4] = '{0, 0, 51, 32};
    logic [TAPS_W-1:0] taps_plan [4];
    taps_plan = '{MAX_TAPS, 1, 127, TAPS_W'($urandom_range(2, MAX_TAPS - 1))};
    for (int ph = 0; ph < 4; ph++) begin
      set_taps(taps_plan[ph]);
      src_idle_pct   = src_plan[ph];
      sink_stall_pct = sink_plan[ph];
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
  endtask

  // Receiver holds off while samples keep coming: the result buffer fills
  // and the input has to stall.
  task automatic test_backpressure();
    set_taps(TAPS_W'($urandom_range(1, MAX_TAPS)));
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_left      = HOLD_OFF_CYCLES;
    repeat (24) send_sample(rand_sample());
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst              = 1'b1;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    din_if.valid     = 1'b0;
    din_if.req_type  = REQ_SAMPLE;
    din_if.sample    = '0;
    din_if.tap_index = '0;
    din_if.tap_value = '0;
    dout_if.ready    = 1'b0;
    fail_count       = 0;
    src_idle_pct     = 0;
    sink_stall_pct   = 0;
    hold_left        = 0;
    taps_reg         = TAPS_RESET;
    foreach (history[i]) history[i] = '0;
    foreach (coefs[i]) coefs[i] = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_value();
    test_load_coefficients();
    test_directed();
    test_edge_cases();
    test_random_phases();
    test_backpressure();
    wait_idle();

    if (fail_count == 0 && pending_outputs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
